### src/gwws_pkg.sv
// Package for the greedy word-wrap stream formatter.
// Holds the field widths, the character codes, the register map and reset values.
// No dependencies.
package gwws_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned IndentW = 6;
  localparam int unsigned WidthW  = 10;
  localparam int unsigned ColW    = 11;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [CharW-1:0] CharNewline = 8'd10;
  localparam logic [CharW-1:0] CharSpace   = 8'd32;
  localparam logic [CharW-1:0] CharTab     = 8'd9;
  localparam logic [CharW-1:0] CharCr      = 8'd13;

  localparam logic [ColW-1:0] ColumnMax = {ColW{1'b1}};

  localparam logic [IndentW-1:0] IndentReset = 6'd0;
  localparam logic [WidthW-1:0]  WidthReset  = 10'd72;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    RegIndent = 1'b0,
    RegWidth  = 1'b1
  } reg_idx_e;

endpackage

### src/greedy_word_wrap_stream.sv
// Top level of the greedy word-wrap stream formatter: APB registers, item plan
// register, byte emitter and output register. Depends on gwws_pkg.
//
// Channel | Signals                            | Direction
// in      | in_valid_i, in_stall_o, in_char_i, text_start_i | into block
// out     | out_valid_o, out_stall_i, out_char_o, run_last_o | out of block
// cfg     | psel_i, penable_i, pwrite_i, paddr_i, pwdata_i, prdata_o, pready_o | APB
//
// An item that yields one byte or none does not stall the input while the output flows;
// a longer item stalls the input until its last byte is sent, as the emitter sends one
// byte per cycle when not stalled: indent spaces, then the body byte, then indent spaces.
// The wrap mode and column are updated when the item is accepted.
// Reset clears the mode, the column and all valid flags and sets the registers to defaults.
// A stalled output holds its byte while the next item waits in the plan register.
module greedy_word_wrap_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gwws_pkg::CharW-1:0]  in_char_i,
  input  logic                        text_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gwws_pkg::CharW-1:0]  out_char_o,
  output logic                        run_last_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [gwws_pkg::AddrW-1:0]  paddr_i,
  input  logic [gwws_pkg::DataW-1:0]  pwdata_i,
  output logic [gwws_pkg::DataW-1:0]  prdata_o,
  output logic                        pready_o
);
  import gwws_pkg::*;

  typedef enum logic [1:0] {
    ModeLineStart = 2'd0,
    ModeInWs      = 2'd1,
    ModeInWord    = 2'd2
  } mode_e;

  logic [IndentW-1:0] indent_q;
  logic [WidthW-1:0]  width_q;
  mode_e              mode_q, mode_d;
  logic [ColW-1:0]    col_q, col_d;

  logic               busy_q, busy_d;
  logic [IndentW-1:0] pre_q, pre_d;
  logic               body_q, body_d;
  logic [CharW-1:0]   body_char_q, body_char_d;
  logic [IndentW-1:0] post_q, post_d;

  logic               out_valid_q;
  logic [CharW-1:0]   out_char_q;
  logic               run_last_q;

  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic               in_accept;
  logic               can_emit, emit;
  logic [IndentW-1:0] pre_nx, post_nx;
  logic               body_nx, rem_zero;
  logic [CharW-1:0]   emit_char;

  logic               is_ws, over;
  mode_e              mode_eff;
  logic [ColW-1:0]    col_eff, col_inc;
  logic [IndentW-1:0] plan_pre, plan_post;
  logic               plan_body;
  logic [CharW-1:0]   plan_char;

  // Configuration port.
  assign pready_o = 1'b1;
  assign cfg_idx  = reg_idx_e'(paddr_i[2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    case (cfg_idx)
      RegIndent: prdata_o = DataW'(indent_q);
      RegWidth:  prdata_o = DataW'(width_q);
      default:   prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indent_q <= IndentReset;
      width_q  <= WidthReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegIndent: indent_q <= pwdata_i[IndentW-1:0];
        RegWidth:  width_q  <= pwdata_i[WidthW-1:0];
        default:   ;
      endcase
    end
  end

  // Emitter: next byte of the current plan.
  assign can_emit = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && can_emit;

  always_comb begin
    pre_nx    = pre_q;
    body_nx   = body_q;
    post_nx   = post_q;
    emit_char = CharSpace;
    if (pre_q != '0) begin
      pre_nx = pre_q - IndentW'(1);
    end else if (body_q) begin
      body_nx   = 1'b0;
      emit_char = body_char_q;
    end else begin
      post_nx = post_q - IndentW'(1);
    end
  end

  assign rem_zero   = (pre_nx == '0) && !body_nx && (post_nx == '0);
  assign in_stall_o = busy_q && !(emit && rem_zero);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Plan for a new item and the next wrap state.
  assign is_ws    = (in_char_i == CharSpace) || (in_char_i >= CharTab && in_char_i <= CharCr);
  assign mode_eff = text_start_i ? ModeLineStart : mode_q;
  assign col_eff  = text_start_i ? ColW'(indent_q) : col_q;
  assign over     = col_eff > ColW'(width_q);
  assign col_inc  = (col_eff == ColumnMax) ? col_eff : col_eff + ColW'(1);

  always_comb begin
    plan_pre  = text_start_i ? indent_q : '0;
    plan_post = '0;
    plan_body = 1'b0;
    plan_char = in_char_i;
    mode_d    = mode_eff;
    col_d     = col_eff;
    case (mode_eff)
      ModeInWs, ModeInWord: begin
        if (is_ws) begin
          if (over) begin
            plan_body = 1'b1;
            plan_char = CharNewline;
            plan_post = indent_q;
            col_d     = ColW'(indent_q);
            mode_d    = ModeLineStart;
          end else if (mode_eff == ModeInWord) begin
            plan_body = 1'b1;
            plan_char = CharSpace;
            col_d     = col_inc;
            mode_d    = ModeInWs;
          end
        end else begin
          plan_body = 1'b1;
          col_d     = col_inc;
          mode_d    = ModeInWord;
        end
      end
      default: begin
        if (is_ws) begin
          mode_d = ModeInWs;
        end else begin
          plan_body = 1'b1;
          col_d     = col_inc;
          mode_d    = ModeInWord;
        end
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pre_d       = pre_q;
    body_d      = body_q;
    body_char_d = body_char_q;
    post_d      = post_q;
    if (emit) begin
      busy_d = !rem_zero;
      pre_d  = pre_nx;
      body_d = body_nx;
      post_d = post_nx;
    end
    if (in_accept) begin
      busy_d      = (plan_pre != '0) || plan_body || (plan_post != '0);
      pre_d       = plan_pre;
      body_d      = plan_body;
      body_char_d = plan_char;
      post_d      = plan_post;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLineStart;
      col_q  <= '0;
      busy_q <= 1'b0;
      pre_q  <= '0;
      body_q <= 1'b0;
      post_q <= '0;
    end else begin
      if (in_accept) begin
        mode_q <= mode_d;
        col_q  <= col_d;
      end
      busy_q <= busy_d;
      pre_q  <= pre_d;
      body_q <= body_d;
      post_q <= post_d;
    end
  end

  always_ff @(posedge clk_i) begin
    body_char_q <= body_char_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= emit_char;
      run_last_q <= rem_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the greedy word-wrap stream formatter.
// Drives bytes through the input channel, predicts the wrapped output and compares it byte by byte.
// Depends on gwws_pkg and greedy_word_wrap_stream.
module testbench;
  import gwws_pkg::*;

  localparam int LimitCycles = 2000000;
  localparam int DrainCycles = 12;
  localparam int PhaseItems  = 40;

  typedef enum logic [1:0] {
    ModeLineStart = 2'd0,
    ModeInWs      = 2'd1,
    ModeInWord    = 2'd2
  } wrap_mode_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             start;
  } text_item_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } wrap_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CharW-1:0]  in_char_i = '0;
  logic              text_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CharW-1:0]  out_char_o;
  logic              run_last_o;
  logic              psel_i = 1'b0;
  logic              penable_i = 1'b0;
  logic              pwrite_i = 1'b0;
  logic [AddrW-1:0]  paddr_i = '0;
  logic [DataW-1:0]  pwdata_i = '0;
  logic [DataW-1:0]  prdata_o;
  logic              pready_o;

  greedy_word_wrap_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_char_i    (in_char_i),
    .text_start_i (text_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .psel_i       (psel_i),
    .penable_i    (penable_i),
    .pwrite_i     (pwrite_i),
    .paddr_i      (paddr_i),
    .pwdata_i     (pwdata_i),
    .prdata_o     (prdata_o),
    .pready_o     (pready_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  text_item_t     pending_q[$];
  wrap_byte_t     wrapped_q[$];
  wrap_byte_t     run_q[$];

  logic [IndentW-1:0] indent_q = IndentReset;
  logic [WidthW-1:0]  width_q = WidthReset;
  wrap_mode_e         mode_q = ModeLineStart;
  logic [ColW-1:0]    col_q = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int items_accepted = 0;
  int bytes_checked = 0;
  int settings_used = 1;
  int cycles = 0;

  function automatic logic is_blank(logic [CharW-1:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic void emit(logic [CharW-1:0] c);
    wrap_byte_t b;
    b.ch = c;
    b.last = 1'b0;
    run_q.push_back(b);
  endfunction

  function automatic void emit_indent();
    for (int i = 0; i < int'(indent_q); i++) emit(CharSpace);
  endfunction

  function automatic void bump_column();
    if (col_q != ColumnMax) col_q = col_q + 1'b1;
  endfunction

  function automatic void break_line();
    emit(CharNewline);
    emit_indent();
    col_q = ColW'(indent_q);
    mode_q = ModeLineStart;
  endfunction

  // Updates the wrap state for one accepted item and queues the bytes it yields.
  function automatic void predict_wrap(logic [CharW-1:0] c, logic start);
    logic ws;
    wrap_byte_t b;
    ws = is_blank(c);
    run_q.delete();
    if (start) begin
      emit_indent();
      col_q = ColW'(indent_q);
      mode_q = ModeLineStart;
    end
    case (mode_q)
      ModeInWs: begin
        if (ws) begin
          if (col_q > ColW'(width_q)) break_line();
        end else begin
          emit(c);
          bump_column();
          mode_q = ModeInWord;
        end
      end
      ModeInWord: begin
        if (ws) begin
          if (col_q > ColW'(width_q)) begin
            break_line();
          end else begin
            emit(CharSpace);
            bump_column();
            mode_q = ModeInWs;
          end
        end else begin
          emit(c);
          bump_column();
        end
      end
      default: begin
        if (ws) begin
          mode_q = ModeInWs;
        end else begin
          emit(c);
          bump_column();
          mode_q = ModeInWord;
        end
      end
    endcase
    for (int i = 0; i < run_q.size(); i++) begin
      b = run_q[i];
      b.last = (i == run_q.size() - 1);
      wrapped_q.push_back(b);
    end
  endfunction

  always @(posedge clk_i) begin
    text_item_t nxt;
    if (in_valid_i && !in_stall_o) begin
      predict_wrap(in_char_i, text_start_i);
      items_accepted++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        in_char_i <= nxt.ch;
        text_start_i <= nxt.start;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    wrap_byte_t want;
    if (out_valid_o && !out_stall_i) begin
      if (wrapped_q.size() == 0) begin
        $display("%0t: unexpected byte %0d last %0b", $time, out_char_o, run_last_o);
        errors++;
      end else begin
        want = wrapped_q.pop_front();
        bytes_checked++;
        if (out_char_o !== want.ch) begin
          $display("%0t: out_char expected %0d actual %0d", $time, want.ch, out_char_o);
          errors++;
        end
        if (run_last_o !== want.last) begin
          $display("%0t: run_last expected %0b actual %0b", $time, want.last, run_last_o);
          errors++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("%0t: timeout with %0d bytes still expected", $time, wrapped_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_access(reg_idx_e idx, logic wr, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= wr;
    paddr_i <= {idx, 2'b00};
    pwdata_i <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (!wr && prdata_o !== val) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, val, prdata_o);
      errors++;
    end
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  task automatic set_format(int indent, int width);
    cfg_access(RegIndent, 1'b1, DataW'(indent));
    indent_q = IndentW'(indent);
    cfg_access(RegWidth, 1'b1, DataW'(width));
    width_q = WidthW'(width);
    cfg_access(RegIndent, 1'b0, DataW'(indent_q));
    cfg_access(RegWidth, 1'b0, DataW'(width_q));
    settings_used++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || wrapped_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic void push_item(int c, bit start);
    text_item_t it;
    it.ch = CharW'(c);
    it.start = start;
    pending_q.push_back(it);
  endfunction

  function automatic logic [CharW-1:0] word_byte();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [CharW-1:0] blank_byte();
    logic [CharW-1:0] c;
    if ($urandom_range(2) == 0) begin
      c = CharSpace;
    end else begin
      c = CharW'($urandom_range(int'(CharCr), int'(CharTab)));
    end
    return c;
  endfunction

  // Mostly well-formed texts of words and blank runs, with some loose noise bytes.
  // The last text is cut so that exactly n items are queued.
  function automatic void queue_texts(int n);
    int count;
    int words;
    bit first;
    count = 0;
    while (count < n) begin
      if ($urandom_range(9) == 0) begin
        push_item($urandom_range(255), 1'($urandom_range(1)));
        count++;
      end else begin
        words = $urandom_range(8, 1);
        first = 1'b1;
        if ($urandom_range(3) == 0) begin
          push_item(blank_byte(), 1'b1);
          first = 1'b0;
          count++;
        end
        for (int w = 0; w < words; w++) begin
          repeat ($urandom_range(12, 1)) begin
            push_item(word_byte(), first);
            first = 1'b0;
            count++;
          end
          repeat ($urandom_range(3, 1)) begin
            push_item(blank_byte(), 1'b0);
            count++;
          end
        end
      end
    end
    repeat (count - n) void'(pending_q.pop_back());
  endfunction

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  int phase_indent[8] = '{63, 0, 7, 1, 0, 63, 3, 20};
  int phase_width[8]  = '{0, 1023, 12, 1, 0, 1023, 30, 60};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any text start, then every blank code and the byte extremes.
    @(negedge clk_i);
    push_item("x", 1'b0);
    push_item(" ", 1'b0);
    push_item(" ", 1'b0);
    push_item(8'h00, 1'b0);
    push_item(" ", 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h0B, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h0C, 1'b0);
    push_item(8'h0D, 1'b0);
    push_item(8'h0A, 1'b0);
    push_item(8'h09, 1'b0);
    push_item(8'h7F, 1'b0);
    wait_drained();

    // Narrow lines: breaks from a word and from a blank run.
    set_format(2, 3);
    set_idling(1);
    @(negedge clk_i);
    push_item("a", 1'b1);
    push_item("b", 1'b0);
    push_item("c", 1'b0);
    push_item(" ", 1'b0);
    push_item(" ", 1'b0);
    push_item("d", 1'b0);
    push_item(" ", 1'b0);
    push_item(" ", 1'b0);
    push_item("e", 1'b0);
    push_item("f", 1'b0);
    push_item(8'h09, 1'b0);
    push_item("i", 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 4) begin
        set_format($urandom_range(63), $urandom_range(40));
      end else if (p == 7) begin
        set_format($urandom_range(63), $urandom_range(1023));
      end else begin
        set_format(phase_indent[p], phase_width[p]);
      end
      set_idling(p);
      @(negedge clk_i);
      queue_texts(PhaseItems);
      wait_drained();
    end

    // One long word runs well past the width before a blank breaks it.
    set_format(0, 20);
    set_idling(3);
    @(negedge clk_i);
    push_item(word_byte(), 1'b1);
    repeat (29) push_item(word_byte(), 1'b0);
    push_item(" ", 1'b0);
    push_item(" ", 1'b0);
    push_item("z", 1'b0);
    wait_drained();

    $display("Run covered %0d items and %0d output bytes under %0d register settings.",
             items_accepted, bytes_checked, settings_used);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
